// ===== sv/stp_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_seq_pkg
// Shared types, action codes, reciprocal constants and the half-step coil
// pattern table for the stepper half-step move sequencer.
// ----------------------------------------------------------------------------
package stp_seq_pkg;

  // Action codes of an input word
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_STEPS = 2'd1;
  localparam logic [1:0] ACT_ANGLE = 2'd2;

  // Field widths fixed by the interface
  localparam int AMT_W   = 16;
  localparam int DWELL_W = 10;
  localparam int PHASE_W = 3;
  localparam int COIL_W  = 4;

  // Degrees in one turn; angle reduction works modulo this
  localparam int DEG_MOD = 360;
  localparam int DEG_W   = 9;   // holds 0..359
  localparam int DEG_Q_W = 8;   // 65535 / 360 = 182

  // floor(a / 360) for 16-bit a: (a * DEG_RECIP) >> DEG_SHIFT, exact
  localparam int DEG_SHIFT   = 25;
  localparam int DEG_RECIP   = ((2 ** DEG_SHIFT) + DEG_MOD - 1) / DEG_MOD;
  localparam int DEG_RECIP_W = 17;

  // floor(p / 360) for p = deg * steps_per_rev up to 359 * 8192, exact
  localparam int    ANG_SHIFT   = 32;
  localparam longint ANG_RECIP  = ((64'd1 << ANG_SHIFT) + 64'd359) / 64'd360;
  localparam int    ANG_RECIP_W = 24;

  // Command word handed from the conversion pipe to the sequencer
  typedef struct packed {
    logic [1:0] action;
    logic       cw;
    logic       legal;
  } stp_cmd_t;

  // 8-phase half-step coil pattern, phase 0 is the first phase
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    unique case (ph)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/stp_angle_pipe.sv =====
// ----------------------------------------------------------------------------
// stp_angle_pipe
// Five-stage input pipeline: registers the word, reduces an angle modulo
// 360 and scales it to half steps with reciprocal multiplies, and range
// checks a half-step count. Stages advance independently on valid/stall.
// ----------------------------------------------------------------------------
module stp_angle_pipe
  import stp_seq_pkg::*;
#(
  parameter int STEPS_PER_REV = 4096,
  localparam int CNT_W = $clog2(STEPS_PER_REV + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic             clockwise,
  input  logic [AMT_W-1:0] amount,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output stp_cmd_t         cmd,
  output logic [CNT_W-1:0] cmd_cnt
);

  localparam int NSTG       = 5;
  localparam int DEG_PROD_W = AMT_W + DEG_RECIP_W;
  localparam int PROD_W     = $clog2((DEG_MOD - 1) * STEPS_PER_REV + 1);
  localparam int WIDE_W     = PROD_W + ANG_RECIP_W;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  // stage payloads
  logic [1:0]         s0_action, s1_action, s2_action, s3_action;
  logic               s0_cw, s1_cw, s2_cw, s3_cw;
  logic [AMT_W-1:0]   s0_amount, s1_amount;
  logic [DEG_Q_W-1:0] s1_quot;
  logic               s1_ok, s2_ok, s3_ok;
  logic [DEG_W-1:0]   s2_deg;
  logic [CNT_W-1:0]   s2_cnt, s3_cnt;
  logic [PROD_W-1:0]  s3_prod;
  stp_cmd_t           s4_cmd;
  logic [CNT_W-1:0]   s4_cnt;

  // per-stage datapath
  logic [DEG_PROD_W-1:0] deg_prod;
  logic [DEG_Q_W-1:0]    quot_next;
  logic                  ok_next;
  logic [AMT_W-1:0]      deg_sub;
  logic [DEG_W-1:0]      deg_next;
  logic [PROD_W-1:0]     prod_next;
  logic [WIDE_W-1:0]     wide;
  logic [CNT_W-1:0]      ang_cnt;
  stp_cmd_t              cmd_next;
  logic [CNT_W-1:0]      cnt_next;

  // ready chain: a stage loads when it is empty or its word moves on
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !cmd_stall;
    for (int k = 0; k < NSTG - 1; k++) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: quotient of amount / 360, count range check
  assign deg_prod  = DEG_PROD_W'(s0_amount) * DEG_PROD_W'(DEG_RECIP);
  assign quot_next = deg_prod[DEG_SHIFT +: DEG_Q_W];
  assign ok_next   = s0_amount <= AMT_W'(STEPS_PER_REV);

  // stage 2: remainder in degrees
  assign deg_sub  = AMT_W'(s1_quot) * AMT_W'(DEG_MOD);
  assign deg_next = DEG_W'(s1_amount - deg_sub);

  // stage 3: degrees times steps per turn
  assign prod_next = PROD_W'(s2_deg) * PROD_W'(STEPS_PER_REV);

  // stage 4: divide by 360, pick the move count
  assign wide    = WIDE_W'(s3_prod) * WIDE_W'(ANG_RECIP);
  assign ang_cnt = wide[ANG_SHIFT +: CNT_W];

  always_comb begin
    cmd_next.action = s3_action;
    cmd_next.cw     = s3_cw;
    cmd_next.legal  = (s3_action == ACT_ANGLE) || s3_ok;
    cnt_next        = (s3_action == ACT_ANGLE) ? ang_cnt : s3_cnt;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_action <= action;
      s0_cw     <= clockwise;
      s0_amount <= amount;
    end
    if (rdy[1]) begin
      s1_action <= s0_action;
      s1_cw     <= s0_cw;
      s1_amount <= s0_amount;
      s1_quot   <= quot_next;
      s1_ok     <= ok_next;
    end
    if (rdy[2]) begin
      s2_action <= s1_action;
      s2_cw     <= s1_cw;
      s2_deg    <= deg_next;
      s2_cnt    <= s1_amount[CNT_W-1:0];
      s2_ok     <= s1_ok;
    end
    if (rdy[3]) begin
      s3_action <= s2_action;
      s3_cw     <= s2_cw;
      s3_prod   <= prod_next;
      s3_cnt    <= s2_cnt;
      s3_ok     <= s2_ok;
    end
    if (rdy[4]) begin
      s4_cmd <= cmd_next;
      s4_cnt <= cnt_next;
    end
  end

  assign cmd_valid = vld[NSTG-1];
  assign cmd       = s4_cmd;
  assign cmd_cnt   = s4_cnt;

endmodule

// ===== sv/stp_seq_core.sv =====
// ----------------------------------------------------------------------------
// stp_seq_core
// Move state (remaining steps, phase, direction, dwell) and the result
// register. Takes one command or tick word per cycle while the result
// register is not stalled, and updates the state as it takes the word.
// ----------------------------------------------------------------------------
module stp_seq_core
  import stp_seq_pkg::*;
#(
  parameter int STEPS_PER_REV = 4096,
  localparam int CNT_W = $clog2(STEPS_PER_REV + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [DWELL_W-1:0] cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  stp_cmd_t           cmd,
  input  logic [CNT_W-1:0]   cmd_cnt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COIL_W-1:0]  coils,
  output logic               busy_res,
  output logic               accepted,
  output logic [CNT_W-1:0]   steps_left
);

  // state
  logic [DWELL_W-1:0] ticks;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic               move_cw, move_cw_next;
  logic [DWELL_W-1:0] dwell, dwell_next;

  logic               take;
  logic [DWELL_W-1:0] limit;
  logic [DWELL_W-1:0] dwell_inc;
  logic [COIL_W-1:0]  coils_next;
  logic               acc_next;

  assign cmd_stall = out_valid && out_stall;
  assign take      = cmd_valid && !cmd_stall;

  // a dwell of zero ticks behaves as one
  assign limit     = (ticks == '0) ? DWELL_W'(1) : ticks;
  assign dwell_inc = dwell + 1'b1;

  // next state and result
  always_comb begin
    rem_next     = rem;
    phase_next   = phase;
    move_cw_next = move_cw;
    dwell_next   = dwell;
    coils_next   = '0;
    acc_next     = 1'b0;
    if (cmd.action == ACT_TICK) begin
      if (rem != '0) begin
        coils_next = coil_pattern(phase);
        if (dwell_inc >= limit) begin
          dwell_next = '0;
          rem_next   = rem - 1'b1;
          phase_next = move_cw ? phase - 1'b1 : phase + 1'b1;
        end else begin
          dwell_next = dwell_inc;
        end
      end
    end else begin
      // start a move only from idle
      if ((rem == '0) && cmd.legal &&
          ((cmd.action == ACT_STEPS) || (cmd.action == ACT_ANGLE))) begin
        rem_next     = cmd_cnt;
        move_cw_next = cmd.cw;
        phase_next   = cmd.cw ? PHASE_W'(7) : PHASE_W'(0);
        dwell_next   = '0;
        acc_next     = 1'b1;
      end
      if (rem_next != '0) begin
        coils_next = coil_pattern(phase_next);
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= DWELL_W'(1);
    end else if (cfg_write) begin
      ticks <= cfg_data;
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      rem     <= '0;
      phase   <= '0;
      move_cw <= 1'b0;
      dwell   <= '0;
    end else if (take) begin
      rem     <= rem_next;
      phase   <= phase_next;
      move_cw <= move_cw_next;
      dwell   <= dwell_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      coils      <= coils_next;
      busy_res   <= rem_next != '0;
      accepted   <= acc_next;
      steps_left <= rem_next;
    end
  end

  // remaining count only ever holds or drops by one while a move runs
  a_rem_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(rem) != '0) |->
      (rem == $past(rem)) || (rem == $past(rem) - 1'b1))
    else $error("remaining steps jumped during a move");

  // a command taken while busy is never reported accepted
  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    take && (rem != '0) |=> !accepted)
    else $error("command accepted while a move was running");

  // ticks while idle leave the motor state alone
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.action == ACT_TICK) && (rem == '0) |=>
      (rem == '0) && $stable(phase) && !busy_res && (coils == '0))
    else $error("idle tick changed state or drove coils");

endmodule

// ===== sv/stepper_half_step_move_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_move_sequencer_core
// Half-step sequencer for the four coil lines of a unipolar stepper. Each
// input word is a tick or a move command (half-step count, or an angle in
// degrees reduced modulo 360 and scaled to STEPS_PER_REV half steps per
// turn); each word yields one result word with the coil drive, busy flag,
// accept flag and steps left. One word is taken per clock cycle while
// in_stall is low. An input register and four pipeline stages carry the
// angle reduction and scaling (a reciprocal multiply for the quotient, a
// multiply-subtract for the remainder, the scale by STEPS_PER_REV and a
// reciprocal multiply for the division by 360), after which the move state
// updates into the result register. Backpressure on the result side fills
// the pipeline stages before the input is stalled. ticks_per_step is
// written through cfg_write/cfg_data and resets to 1.
// ----------------------------------------------------------------------------
module stepper_half_step_move_sequencer_core
  import stp_seq_pkg::*;
#(
  parameter int STEPS_PER_REV = 4096,
  localparam int CNT_W = $clog2(STEPS_PER_REV + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [DWELL_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic               clockwise,
  input  logic [AMT_W-1:0]   amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COIL_W-1:0]  coils,
  output logic               busy_res,
  output logic               accepted,
  output logic [CNT_W-1:0]   steps_left
);

  logic             cmd_valid;
  logic             cmd_stall;
  stp_cmd_t         cmd;
  logic [CNT_W-1:0] cmd_cnt;

  // input register and angle conversion
  stp_angle_pipe #(
    .STEPS_PER_REV(STEPS_PER_REV)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .clockwise (clockwise),
    .amount    (amount),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .cmd_cnt   (cmd_cnt)
  );

  // move state and result register
  stp_seq_core #(
    .STEPS_PER_REV(STEPS_PER_REV)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .cmd_cnt    (cmd_cnt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coils      (coils),
    .busy_res   (busy_res),
    .accepted   (accepted),
    .steps_left (steps_left)
  );

endmodule
